// ===== rtl/trsc_pkg.sv =====
// ----------------------------------------------------------------------------
// trsc_pkg: shared types and constants of the three-rotor substitution cipher
// Field widths, operation and rotor codes, ASCII letter bounds and the
// structs that pass between the cipher modules.
// ----------------------------------------------------------------------------
package trsc_pkg;

  // Field widths
  localparam int LETTER_W     = 5;
  localparam int ROTOR_SEL_W  = 2;
  localparam int CHAR_W       = 8;
  localparam int ROTOR_COUNT  = 3;
  localparam int MOD_LUT_SIZE = 1 << LETTER_W;

  // Operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_CIPHER = 1'b1;

  // Rotor select codes
  localparam logic [ROTOR_SEL_W-1:0] ROTOR_FIRST  = 2'd0;
  localparam logic [ROTOR_SEL_W-1:0] ROTOR_SECOND = 2'd1;
  localparam logic [ROTOR_SEL_W-1:0] ROTOR_THIRD  = 2'd2;

  // ASCII letter bounds
  localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'd97;
  localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'd122;
  localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'd65;
  localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'd90;

  // One request as held in the input register
  typedef struct packed {
    logic                   op;
    logic [ROTOR_SEL_W-1:0] rotor_select;
    logic [LETTER_W-1:0]    entry_index;
    logic [LETTER_W-1:0]    entry_value;
    logic [CHAR_W-1:0]      char_in;
  } trsc_item_t;

  // Table write port of the rotor bank
  typedef struct packed {
    logic                   en;
    logic [ROTOR_SEL_W-1:0] rotor;
    logic [LETTER_W-1:0]    index;
    logic [LETTER_W-1:0]    value;
  } trsc_load_t;

  // Current turn offsets of the three rotors
  typedef struct packed {
    logic [LETTER_W-1:0] first;
    logic [LETTER_W-1:0] second;
    logic [LETTER_W-1:0] third;
  } trsc_offsets_t;

endpackage

// ===== rtl/trsc_req_if.sv =====
// ----------------------------------------------------------------------------
// trsc_req_if: request channel of the cipher
// Valid/ready channel carrying one load or one character request.
// ----------------------------------------------------------------------------
interface trsc_req_if import trsc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [ROTOR_SEL_W-1:0] rotor_select;
  logic [LETTER_W-1:0]    entry_index;
  logic [LETTER_W-1:0]    entry_value;
  logic [CHAR_W-1:0]      char_in;

  modport source (
    output valid, op, rotor_select, entry_index, entry_value, char_in,
    input  ready
  );

  modport sink (
    input  valid, op, rotor_select, entry_index, entry_value, char_in,
    output ready
  );
endinterface

// ===== rtl/trsc_res_if.sv =====
// ----------------------------------------------------------------------------
// trsc_res_if: result channel of the cipher
// Valid/ready channel carrying one enciphered or passed-through byte.
// ----------------------------------------------------------------------------
interface trsc_res_if import trsc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;

  modport source (
    output valid, char_out,
    input  ready
  );

  modport sink (
    input  valid, char_out,
    output ready
  );
endinterface

// ===== rtl/trsc_rotor_bank.sv =====
// ----------------------------------------------------------------------------
// trsc_rotor_bank: rotor tables and lookup chain
// Holds the three rotor tables, takes table writes and passes a letter index
// through the three rotors at their current offsets.
// ----------------------------------------------------------------------------
module trsc_rotor_bank import trsc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                clk,
  input  trsc_load_t          load,
  input  trsc_offsets_t       offsets,
  input  logic [LETTER_W-1:0] letter_index,
  output logic [LETTER_W-1:0] cipher_index
);

  localparam int IW = $clog2(ALPHABET_SIZE);
  localparam logic [LETTER_W:0] SIZE_EXT = (LETTER_W+1)'(ALPHABET_SIZE);

  logic [LETTER_W-1:0] rotor1_mem [ALPHABET_SIZE];
  logic [LETTER_W-1:0] rotor2_mem [ALPHABET_SIZE];
  logic [LETTER_W-1:0] rotor3_mem [ALPHABET_SIZE];

  // Reduction of any 5-bit value modulo the alphabet size
  logic [LETTER_W-1:0] mod_lut [MOD_LUT_SIZE];

  logic [LETTER_W-1:0] pos1;
  logic [LETTER_W-1:0] pos2;
  logic [LETTER_W-1:0] pos3;
  logic [LETTER_W-1:0] val1;
  logic [LETTER_W-1:0] val2;
  logic [LETTER_W-1:0] val3;
  logic                load_in_range;

  for (genvar k = 0; k < MOD_LUT_SIZE; k++) begin : g_mod_lut
    assign mod_lut[k] = LETTER_W'(k % ALPHABET_SIZE);
  end

  // Add two values below the alphabet size, wrapping once
  function automatic logic [LETTER_W-1:0] wrap_add(
    input logic [LETTER_W-1:0] x,
    input logic [LETTER_W-1:0] y
  );
    logic [LETTER_W:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= SIZE_EXT) begin
      sum = sum - SIZE_EXT;
    end
    return sum[LETTER_W-1:0];
  endfunction

  // Drop writes past the end of a table
  assign load_in_range = load.en && ({1'b0, load.index} < SIZE_EXT);

  // Write one table entry
  always_ff @(posedge clk) begin
    if (load_in_range) begin
      case (load.rotor)
        ROTOR_FIRST:  rotor1_mem[load.index[IW-1:0]] <= load.value;
        ROTOR_SECOND: rotor2_mem[load.index[IW-1:0]] <= load.value;
        ROTOR_THIRD:  rotor3_mem[load.index[IW-1:0]] <= load.value;
        default: begin
        end
      endcase
    end
  end

  // Pass the letter through the three rotors
  always_comb begin
    pos1         = wrap_add(mod_lut[letter_index], offsets.first);
    val1         = rotor1_mem[pos1[IW-1:0]];
    pos2         = wrap_add(mod_lut[val1], offsets.second);
    val2         = rotor2_mem[pos2[IW-1:0]];
    pos3         = wrap_add(mod_lut[val2], offsets.third);
    val3         = rotor3_mem[pos3[IW-1:0]];
    cipher_index = mod_lut[val3];
  end

endmodule

// ===== rtl/trsc_stepper.sv =====
// ----------------------------------------------------------------------------
// trsc_stepper: rotor offset counters
// Advances the first rotor once per character and carries a full turn into
// the next rotor, like an odometer.
// ----------------------------------------------------------------------------
module trsc_stepper import trsc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  output trsc_offsets_t offsets
);

  localparam logic [LETTER_W-1:0] LAST_POS = LETTER_W'(ALPHABET_SIZE - 1);

  trsc_offsets_t offsets_next;
  logic          first_wrap;
  logic          second_wrap;

  // Compute the stepped offsets
  always_comb begin
    offsets_next = offsets;
    first_wrap   = (offsets.first == LAST_POS);
    second_wrap  = (offsets.second == LAST_POS);
    if (step) begin
      offsets_next.first = first_wrap ? '0 : offsets.first + LETTER_W'(1);
      if (first_wrap) begin
        offsets_next.second = second_wrap ? '0 : offsets.second + LETTER_W'(1);
        if (second_wrap) begin
          offsets_next.third = (offsets.third == LAST_POS) ? '0
                               : offsets.third + LETTER_W'(1);
        end
      end
    end
  end

  // Hold the offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      offsets <= '0;
    end else begin
      offsets <= offsets_next;
    end
  end

endmodule

// ===== rtl/three_rotor_substitution_cipher_top.sv =====
// An accepted request is held in the input register; a character then passes
// through the combinational rotor lookup chain into the result register.
// Throughput: one request per cycle unless a held result stalls a character,
// set by the single input and result registers around the lookup chain.
// Reset: rst clears the rotor offsets and both valid flags; rotor tables are
// undefined until loaded.
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher_top: three-rotor substitution cipher
// Takes table loads and characters; enciphers letters through three stepping
// rotors and passes other bytes unchanged.
// ----------------------------------------------------------------------------
module three_rotor_substitution_cipher_top import trsc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic       clk,
  input  logic       rst,
  trsc_req_if.sink   cipher_req,
  trsc_res_if.source cipher_res
);

  logic                s1_valid;
  trsc_item_t          s1_item;
  logic                s1_go;
  logic                step;
  trsc_load_t          load;
  trsc_offsets_t       offsets;
  logic                is_lower;
  logic                is_upper;
  logic [CHAR_W-1:0]   base;
  logic [LETTER_W-1:0] letter_index;
  logic [LETTER_W-1:0] cipher_index;
  logic [CHAR_W-1:0]   cipher_char;
  logic                res_valid;
  logic [CHAR_W-1:0]   res_char;

  // Advance the input register when its request can retire
  assign s1_go = s1_valid && ((s1_item.op == OP_LOAD) || !res_valid || cipher_res.ready);
  assign cipher_req.ready = !s1_valid || s1_go;
  assign step = s1_go && (s1_item.op == OP_CIPHER);

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cipher_req.ready) begin
      s1_valid <= cipher_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cipher_req.valid && cipher_req.ready) begin
      s1_item.op           <= cipher_req.op;
      s1_item.rotor_select <= cipher_req.rotor_select;
      s1_item.entry_index  <= cipher_req.entry_index;
      s1_item.entry_value  <= cipher_req.entry_value;
      s1_item.char_in      <= cipher_req.char_in;
    end
  end

  // Route a load request to the tables
  always_comb begin
    load.en    = s1_valid && (s1_item.op == OP_LOAD);
    load.rotor = s1_item.rotor_select;
    load.index = s1_item.entry_index;
    load.value = s1_item.entry_value;
  end

  // Classify the byte and strip the letter base
  always_comb begin
    is_lower     = s1_item.char_in inside {[LOWER_FIRST:LOWER_LAST]};
    is_upper     = s1_item.char_in inside {[UPPER_FIRST:UPPER_LAST]};
    base         = is_lower ? LOWER_FIRST : UPPER_FIRST;
    letter_index = LETTER_W'(s1_item.char_in - base);
    cipher_char  = (is_lower || is_upper)
                   ? base + {{(CHAR_W-LETTER_W){1'b0}}, cipher_index}
                   : s1_item.char_in;
  end

  trsc_rotor_bank #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_rotor_bank (
    .clk          (clk),
    .load         (load),
    .offsets      (offsets),
    .letter_index (letter_index),
    .cipher_index (cipher_index)
  );

  trsc_stepper #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_stepper (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .offsets (offsets)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (cipher_res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_char <= cipher_char;
    end
  end

  assign cipher_res.valid    = res_valid;
  assign cipher_res.char_out = res_char;

endmodule

// ===== tb/sv/three_rotor_substitution_cipher_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher_top_tb: self-checking bench of the cipher
// Fills all three rotor tables, runs a short directed set (letter bounds,
// bytes next to them, dropped loads, oversized stored values), then random
// loads and characters under several idle and stall mixes. A scoreboard
// predicts each byte from its own copy of the tables and turn offsets.
// ----------------------------------------------------------------------------
module three_rotor_substitution_cipher_top_tb;
  import trsc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int ALPHA          = 26;
  localparam int PHASE_ITEMS    = 420;
  localparam int HOLD_CYCLES    = 80;
  localparam int TAIL_CYCLES    = 4;
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int REPORT_CAP     = 100;

  // Rotor code that the block drops on a load
  localparam logic [ROTOR_SEL_W-1:0] ROTOR_NONE = 2'd3;

  // Predict enciphered bytes and compare them in arrival order
  class cipher_scoreboard;
    logic [LETTER_W-1:0] wiring [ROTOR_COUNT][ALPHA];
    int                  turn [ROTOR_COUNT];
    logic [CHAR_W-1:0]   expected_chars [$];
    int                  errors;

    function new();
      errors = 0;
      foreach (turn[r]) turn[r] = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function int rotor_out(input int r, input int idx);
      return int'(wiring[r][(idx + turn[r]) % ALPHA]);
    endfunction

    // Apply one accepted request to the predicted state
    function void note(input trsc_item_t it);
      int              a, b, c;
      logic [CHAR_W-1:0] base;
      bit              letter;
      if (it.op == OP_LOAD) begin
        if (it.rotor_select < ROTOR_COUNT && it.entry_index < ALPHA)
          wiring[it.rotor_select][it.entry_index] = it.entry_value;
        return;
      end
      letter = 1'b1;
      if (it.char_in >= LOWER_FIRST && it.char_in <= LOWER_LAST) base = LOWER_FIRST;
      else if (it.char_in >= UPPER_FIRST && it.char_in <= UPPER_LAST) base = UPPER_FIRST;
      else letter = 1'b0;
      if (letter) begin
        a = rotor_out(0, int'(it.char_in - base));
        b = rotor_out(1, a);
        c = rotor_out(2, b);
        expected_chars.push_back(base + CHAR_W'(c % ALPHA));
      end else begin
        expected_chars.push_back(it.char_in);
      end
      // Step like an odometer
      turn[0] = (turn[0] + 1) % ALPHA;
      if (turn[0] == 0) begin
        turn[1] = (turn[1] + 1) % ALPHA;
        if (turn[1] == 0) turn[2] = (turn[2] + 1) % ALPHA;
      end
    endfunction

    task check(input logic [CHAR_W-1:0] got);
      logic [CHAR_W-1:0] want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char_out 0x%02h", got));
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) report($sformatf("char_out 0x%02h, expected 0x%02h", got, want));
      end
    endtask

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  trsc_req_if req_bus ();
  trsc_res_if res_bus ();

  cipher_scoreboard sb = new();

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_token   = 0;

  three_rotor_substitution_cipher_top #(.ALPHABET_SIZE(ALPHA)) uut (
    .clk        (clk),
    .rst        (rst),
    .cipher_req (req_bus),
    .cipher_res (res_bus)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    trsc_item_t seen;
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        seen.op           = req_bus.op;
        seen.rotor_select = req_bus.rotor_select;
        seen.entry_index  = req_bus.entry_index;
        seen.entry_value  = req_bus.entry_value;
        seen.char_in      = req_bus.char_in;
        sb.note(seen);
      end
      if (res_bus.valid && res_bus.ready) sb.check(res_bus.char_out);
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic trsc_item_t load_req(input logic [ROTOR_SEL_W-1:0] sel,
                                          input int idx, input int val);
    trsc_item_t it;
    it.op           = OP_LOAD;
    it.rotor_select = sel;
    it.entry_index  = LETTER_W'(idx);
    it.entry_value  = LETTER_W'(val);
    it.char_in      = CHAR_W'($urandom_range(255));
    return it;
  endfunction

  function automatic trsc_item_t char_req(input logic [CHAR_W-1:0] ch);
    trsc_item_t it;
    it.op           = OP_CIPHER;
    it.rotor_select = ROTOR_SEL_W'($urandom_range(3));
    it.entry_index  = LETTER_W'($urandom_range(31));
    it.entry_value  = LETTER_W'($urandom_range(31));
    it.char_in      = ch;
    return it;
  endfunction

  // Mostly letters, some table rewrites, a little noise that the block drops
  task automatic pick_request(output trsc_item_t it, output bit counts);
    int roll;
    roll = $urandom_range(99);
    counts = 1'b1;
    if (roll < 70) begin
      case ($urandom_range(4))
        0, 1: it = char_req(LOWER_FIRST + CHAR_W'($urandom_range(ALPHA - 1)));
        2, 3: it = char_req(UPPER_FIRST + CHAR_W'($urandom_range(ALPHA - 1)));
        default: it = char_req(CHAR_W'($urandom_range(255)));
      endcase
    end else if (roll < 92) begin
      it = load_req(ROTOR_SEL_W'($urandom_range(ROTOR_COUNT - 1)), $urandom_range(ALPHA - 1),
                    ($urandom_range(9) == 0) ? $urandom_range(31, ALPHA) : $urandom_range(ALPHA - 1));
    end else begin
      counts = 1'b0;
      if ($urandom_range(1)) it = load_req(ROTOR_NONE, $urandom_range(31), $urandom_range(31));
      else it = load_req(ROTOR_SEL_W'($urandom_range(3)), $urandom_range(31, ALPHA),
                         $urandom_range(31));
    end
  endtask

  // Offer one request; called and returns at a falling edge
  task automatic send_req(input trsc_item_t it);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.op           <= it.op;
    req_bus.rotor_select <= it.rotor_select;
    req_bus.entry_index  <= it.entry_index;
    req_bus.entry_value  <= it.entry_value;
    req_bus.char_in      <= it.char_in;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
  endtask

  // Hold the request side low until every predicted byte is back
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    trsc_item_t it;
    bit         counts;
    int         sent;
    logic [CHAR_W-1:0] edge_chars [12];
    edge_chars = '{8'h61, 8'h7a, 8'h41, 8'h5a, 8'h6d, 8'h4d,
                   8'h60, 8'h7b, 8'h40, 8'h5b, 8'h00, 8'hff};
    req_bus.valid        = 1'b0;
    req_bus.op           = OP_LOAD;
    req_bus.rotor_select = ROTOR_FIRST;
    req_bus.entry_index  = '0;
    req_bus.entry_value  = '0;
    req_bus.char_in      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill every table entry before any letter goes through
    for (int r = 0; r < ROTOR_COUNT; r++)
      for (int i = 0; i < ALPHA; i++)
        send_req(load_req(ROTOR_SEL_W'(r), i, $urandom_range(ALPHA - 1)));

    // Letter bounds and the bytes just outside them
    foreach (edge_chars[k]) send_req(char_req(edge_chars[k]));

    // Loads that must be dropped: no rotor, index past the alphabet
    send_req(load_req(ROTOR_NONE, 0, 31));
    send_req(load_req(ROTOR_FIRST, ALPHA, 31));
    send_req(load_req(ROTOR_THIRD, 31, 0));

    // Oversized stored values on the path of the next 'a'
    send_req(load_req(ROTOR_FIRST, sb.turn[0] % ALPHA, 31));
    send_req(load_req(ROTOR_SECOND, (31 + sb.turn[1]) % ALPHA, ALPHA));
    send_req(load_req(ROTOR_THIRD, (ALPHA + sb.turn[2]) % ALPHA, 29));
    send_req(char_req(LOWER_FIRST));
    drain();

    // Random traffic under four idle mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
        default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
      endcase
      // Back up the pipe: results held off while requests keep coming
      if (phase == 0) hold_token++;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick_request(it, counts);
        send_req(it);
        if (counts) sent++;
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
